### hdl/drtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package drtw_pkg;

	localparam int SLOTS = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int POOL = 64;
	localparam int ENT_W = 6;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] END_MARK = CNT_W'(POOL);

	localparam logic OP_PING = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_DELAYED = 1'b1;

	// first member sits in the top bits, so delay lands in tdata[31:0]
	typedef struct packed {
		logic [15:0] port;
		logic [63:0] addr_low;
		logic [63:0] addr_high;
		logic [31:0] tag3;
		logic [31:0] tag2;
		logic [31:0] tag1;
		logic [31:0] tag0;
		logic [31:0] delay;
	} item_t;

	localparam int DATA_W = $bits(item_t);

	typedef struct packed {
		logic [CNT_W-1:0] next;
		item_t            item;
	} entry_t;

	typedef struct packed {
		logic             nonempty;
		logic [ENT_W-1:0] head;
	} slot_t;

endpackage
`default_nettype wire

### hdl/drtw_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module drtw_slot_mem (
	input  wire                          clk,
	input  wire                          we,
	input  wire [drtw_pkg::SLOT_W-1:0]   waddr,
	input  drtw_pkg::slot_t              wdata,
	input  wire                          re,
	input  wire [drtw_pkg::SLOT_W-1:0]   raddr,
	output drtw_pkg::slot_t              rdata
);
	import drtw_pkg::*;

	slot_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hdl/drtw_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module drtw_entry_mem (
	input  wire                         clk,
	input  wire                         we,
	input  wire [drtw_pkg::ENT_W-1:0]   waddr,
	input  drtw_pkg::entry_t            wdata,
	input  wire                         re,
	input  wire [drtw_pkg::ENT_W-1:0]   raddr,
	output drtw_pkg::entry_t            rdata
);
	import drtw_pkg::*;

	entry_t mem [POOL];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hdl/drtw_free_stack.sv
`timescale 1ns / 1ps
`default_nettype none
module drtw_free_stack (
	input  wire                         clk,
	input  wire                         we,
	input  wire [drtw_pkg::ENT_W-1:0]   waddr,
	input  wire [drtw_pkg::ENT_W-1:0]   wdata,
	input  wire                         re,
	input  wire [drtw_pkg::ENT_W-1:0]   raddr,
	output logic [drtw_pkg::ENT_W-1:0]  rdata
);
	import drtw_pkg::*;

	logic [ENT_W-1:0] mem [POOL];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hdl/delayed_reply_timing_wheel_core.sv
// delayed reply timing wheel
// input channel s_*: tuser is the opcode (0 ping request, 1 tick), tdata the request.
// output channel m_*: tuser = {dropped, reply_kind}, tlast marks the last item
// caused by one input item, tdata carries the reply.
// a ping gives one echo item after its slot read; a positive delay also
// stores the request at slot (position + delay) mod 1024, unless the 64-entry pool
// is exhausted, in which case the echo has dropped set.
// a tick drains the current slot newest first, each delayed reply taking an entry
// memory read, then an output load, then advances the position; an empty
// slot gives no item.
// one item is processed at a time: the next input item is taken once the previous
// one has loaded its last result into the output register, which may still be
// waiting on m_tready.
// after reset the slot memory is cleared one slot per cycle and the free stack
// refilled, during which s_tready stays low.
// a stalled receiver holds the output register and the walk waits on it.
`timescale 1ns / 1ps
`default_nettype none
module delayed_reply_timing_wheel_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// delay_ticks, tag_word0..3, client_addr_high, client_addr_low, client_port
	input  wire [drtw_pkg::DATA_W-1:0]   s_tdata,
	// opcode
	input  wire                          s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// reply_delay, reply_tag0..3, dest_addr_high, dest_addr_low, dest_port
	output logic [drtw_pkg::DATA_W-1:0]  m_tdata,
	// reply_kind, dropped
	output logic [1:0]                   m_tuser,
	// last_of_run
	output logic                         m_tlast
);
	import drtw_pkg::*;

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_READ    = 3'd2;
	localparam logic [2:0] ST_PROC    = 3'd3;
	localparam logic [2:0] ST_ENT_RD  = 3'd4;
	localparam logic [2:0] ST_ENT_OUT = 3'd5;

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] pos_q;
	logic [CNT_W-1:0]  count_q;
	logic [ENT_W-1:0]  cur_q;
	logic [ENT_W-1:0]  n_q;
	logic              op_q;
	item_t             item_q;

	logic              out_valid_q;
	item_t             out_item_q;
	logic              out_kind_q;
	logic              out_drop_q;
	logic              out_last_q;

	logic              slot_we, slot_re;
	logic [SLOT_W-1:0] slot_waddr, slot_addr;
	slot_t             slot_wdata, slot_rd;
	logic              ent_we, ent_re;
	entry_t            ent_wdata, ent_rd;
	logic              stk_we, stk_re;
	logic [ENT_W-1:0]  stk_waddr, stk_wdata, stk_rd;

	logic              positive, can_load, have_free, ent_last, out_load;

	assign positive  = (item_q.delay != 32'd0) && !item_q.delay[31];
	assign have_free = (count_q != '0) && (count_q <= CNT_W'(POOL));
	assign can_load  = !out_valid_q || m_tready;
	assign slot_addr = (op_q == OP_TICK) ? pos_q : SLOT_W'(pos_q + item_q.delay[SLOT_W-1:0]);
	assign ent_last  = ent_rd.next[CNT_W-1] || (n_q == ENT_W'(POOL - 1));
	assign out_load  = can_load &&
		((state_q == ST_PROC && op_q == OP_PING) || state_q == ST_ENT_OUT);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_item_q;
	assign m_tuser  = {out_drop_q, out_kind_q};
	assign m_tlast  = out_last_q;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_addr;
		slot_wdata = '0;
		ent_we     = 1'b0;
		ent_wdata  = '0;
		stk_we     = 1'b0;
		stk_waddr  = count_q[ENT_W-1:0];
		stk_wdata  = cur_q;
		unique case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				stk_we     = (clr_q < SLOT_W'(POOL));
				stk_waddr  = clr_q[ENT_W-1:0];
				stk_wdata  = clr_q[ENT_W-1:0];
			end
			ST_PROC: begin
				if (op_q == OP_TICK) begin
					slot_we = slot_rd.nonempty;
				end else if (can_load && positive && have_free) begin
					slot_we         = 1'b1;
					slot_wdata      = '{nonempty: 1'b1, head: stk_rd};
					ent_we          = 1'b1;
					ent_wdata.next  = slot_rd.nonempty ? {1'b0, slot_rd.head} : END_MARK;
					ent_wdata.item  = item_q;
				end
			end
			ST_ENT_OUT: begin
				stk_we = can_load && (count_q < CNT_W'(POOL));
			end
			default: begin
			end
		endcase
	end

	assign slot_re = (state_q == ST_READ);
	assign stk_re  = (state_q == ST_READ);
	assign ent_re  = (state_q == ST_ENT_RD);

	drtw_slot_mem u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_addr), .rdata(slot_rd)
	);

	drtw_entry_mem u_entry (
		.clk(clk), .we(ent_we), .waddr(stk_rd), .wdata(ent_wdata),
		.re(ent_re), .raddr(cur_q), .rdata(ent_rd)
	);

	drtw_free_stack u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(ENT_W'(count_q - 1'b1)), .rdata(stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			count_q     <= CNT_W'(POOL);
			cur_q       <= '0;
			n_q         <= '0;
			op_q        <= OP_PING;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					if (op_q == OP_TICK) begin
						if (slot_rd.nonempty) begin
							cur_q   <= slot_rd.head;
							n_q     <= '0;
							state_q <= ST_ENT_RD;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (can_load) begin
						if (positive && have_free) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ENT_RD: begin
					state_q <= ST_ENT_OUT;
				end
				ST_ENT_OUT: begin
					if (can_load) begin
						if (count_q < CNT_W'(POOL)) begin
							count_q <= count_q + 1'b1;
						end
						n_q <= n_q + 1'b1;
						if (ent_last) begin
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							cur_q   <= ent_rd.next[ENT_W-1:0];
							state_q <= ST_ENT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			item_q <= item_t'(s_tdata);
		end
		if (state_q == ST_PROC && op_q == OP_PING && can_load) begin
			out_item_q <= item_q;
			out_kind_q <= KIND_ECHO;
			out_drop_q <= positive && !have_free;
			out_last_q <= 1'b1;
		end else if (state_q == ST_ENT_OUT && can_load) begin
			out_item_q <= ent_rd.item;
			out_kind_q <= KIND_DELAYED;
			out_drop_q <= 1'b0;
			out_last_q <= ent_last;
		end
	end
endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import drtw_pkg::*;

	typedef struct {
		logic  op;
		item_t data;
	} request_t;

	typedef struct {
		logic  kind;
		logic  drop;
		logic  last;
		item_t data;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [DATA_W-1:0]  s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [DATA_W-1:0]  m_tdata;
	logic [1:0]         m_tuser;
	logic               m_tlast;

	request_t  pending[$];
	reply_t    replies_due[$];
	item_t     slot_list[SLOTS][$];
	int        wheel_pos = 0;
	int        entries_held = 0;
	int        errors = 0;
	int        taken = 0;
	int        total_items = 0;
	int        replies_seen = 0;
	int        drops_seen = 0;
	int        delayed_seen = 0;
	int        phase = 0;
	int        idle_cycles = 0;
	logic      in_fire = 1'b0;

	delayed_reply_timing_wheel_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch on reply %0d: %s got %h expected %h", replies_seen, what, got, want);
	endtask

	// schedule a request or drain a slot, queueing the replies it causes
	task automatic predict_wheel(input request_t r);
		reply_t rep;
		int slot;
		int n;
		if (r.op == OP_PING) begin
			rep.kind = KIND_ECHO;
			rep.drop = 1'b0;
			rep.last = 1'b1;
			rep.data = r.data;
			if ($signed(r.data.delay) > 0) begin
				if (entries_held == POOL) begin
					rep.drop = 1'b1;
				end else begin
					slot = (wheel_pos + int'(r.data.delay[SLOT_W-1:0])) % SLOTS;
					slot_list[slot].push_front(r.data);
					entries_held++;
				end
			end
			replies_due.push_back(rep);
		end else begin
			n = slot_list[wheel_pos].size();
			for (int i = 0; i < n; i++) begin
				rep.kind = KIND_DELAYED;
				rep.drop = 1'b0;
				rep.last = (i == n - 1);
				rep.data = slot_list[wheel_pos][i];
				replies_due.push_back(rep);
			end
			entries_held -= n;
			slot_list[wheel_pos].delete();
			wheel_pos = (wheel_pos + 1) % SLOTS;
		end
	endtask

	always @(posedge clk) begin
		request_t r;
		reply_t want;
		item_t got;
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			r.op = s_tuser;
			r.data = item_t'(s_tdata);
			predict_wheel(r);
			taken++;
		end
		if (m_tvalid && m_tready) begin
			got = item_t'(m_tdata);
			if (replies_due.size() == 0) begin
				report("unexpected item", m_tdata[63:0], '0);
			end else begin
				want = replies_due.pop_front();
				if (m_tuser[0] !== want.kind) report("reply_kind", m_tuser[0], want.kind);
				if (m_tuser[1] !== want.drop) report("dropped", m_tuser[1], want.drop);
				if (m_tlast !== want.last) report("last_of_run", m_tlast, want.last);
				if (got.delay !== want.data.delay) report("reply_delay", got.delay, want.data.delay);
				if (got.tag0 !== want.data.tag0) report("reply_tag0", got.tag0, want.data.tag0);
				if (got.tag1 !== want.data.tag1) report("reply_tag1", got.tag1, want.data.tag1);
				if (got.tag2 !== want.data.tag2) report("reply_tag2", got.tag2, want.data.tag2);
				if (got.tag3 !== want.data.tag3) report("reply_tag3", got.tag3, want.data.tag3);
				if (got.addr_high !== want.data.addr_high)
					report("dest_addr_high", got.addr_high, want.data.addr_high);
				if (got.addr_low !== want.data.addr_low)
					report("dest_addr_low", got.addr_low, want.data.addr_low);
				if (got.port !== want.data.port) report("dest_port", got.port, want.data.port);
				if (want.drop) drops_seen++;
				if (want.kind == KIND_DELAYED) delayed_seen++;
			end
			replies_seen++;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= 4000) begin
			$display("watchdog expired, %0d replies outstanding", replies_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// sender: at most one assignment to s_tvalid per falling edge
	always @(negedge clk) begin
		request_t r;
		logic     go;
		phase = (taken < total_items / 3) ? 0 : (taken < 2 * total_items / 3) ? 1 : 2;
		if (arst_n && (!s_tvalid || in_fire)) begin
			go = pending.size() > 0;
			if (phase == 0 && $urandom_range(99) < 24) go = 1'b0;
			if (phase == 1 && $urandom_range(99) < 72) go = 1'b0;
			if (go) begin
				r = pending.pop_front();
				s_tuser <= r.op;
				s_tdata <= DATA_W'(r.data);
			end
			s_tvalid <= go;
		end
		if (arst_n) begin
			case (phase)
				0: m_tready <= $urandom_range(99) >= 72;
				1: m_tready <= $urandom_range(99) >= 24;
				default: m_tready <= 1'b1;
			endcase
		end
	end

	function automatic item_t rand_item(input logic [31:0] delay);
		item_t it;
		it.delay = delay;
		it.tag0 = $urandom;
		it.tag1 = $urandom;
		it.tag2 = $urandom;
		it.tag3 = $urandom;
		it.addr_high = {$urandom, $urandom};
		it.addr_low = {$urandom, $urandom};
		it.port = $urandom;
		return it;
	endfunction

	task automatic add_ping(input logic [31:0] delay);
		request_t r;
		r.op = OP_PING;
		r.data = rand_item(delay);
		pending.push_back(r);
	endtask

	task automatic add_tick();
		request_t r;
		r.op = OP_TICK;
		r.data = rand_item($urandom);
		pending.push_back(r);
	endtask

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(9))
			0: return $urandom;
			1: return -$urandom_range(5);
			2: return 32'(SLOTS * $urandom_range(1, 3) + $urandom_range(2));
			3: return 32'd0;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	initial begin
		int d;
		item_t extreme;
		request_t r;
		// field extremes: all ones (but a positive delay) and all zeros on an echo
		extreme = '1;
		extreme.delay = 32'h7FFF_FFFF;
		r.op = OP_PING;
		r.data = extreme;
		pending.push_back(r);
		r.data = '0;
		pending.push_back(r);
		add_ping(32'h8000_0000);
		add_ping(32'hFFFF_FFFF);
		add_ping(32'd1);
		add_ping(32'd1);
		add_ping(32'(SLOTS));
		add_ping(32'(2 * SLOTS + 2));
		add_ping(32'd2);
		add_tick(); // whole turn lands in the current slot
		add_tick(); // two entries, newest first
		add_tick();
		add_tick(); // empty slot
		add_ping(32'd3);
		add_tick();
		add_tick();
		// random part: mostly short delays so ticks find work, plus pool floods
		while (pending.size() < 350) begin
			if ($urandom_range(29) == 0) begin
				// flood one slot past the pool size, then drain it
				d = $urandom_range(1, 4);
				for (int i = 0; i < POOL + 3; i++) add_ping(32'(d));
				for (int i = 0; i <= d; i++) add_tick();
			end else if ($urandom_range(99) < 55) begin
				add_ping(rand_delay());
			end else begin
				add_tick();
			end
		end
		// run out the wheel so stored entries come home
		for (int i = 0; i < 14; i++) add_tick();
		total_items = pending.size();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending.size() == 0 && taken == total_items);
		wait (replies_due.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d input items, %0d replies checked (%0d delayed, %0d dropped echoes)",
			taken, replies_seen, delayed_seen, drops_seen);
		$display("%0d entries still parked on the wheel, %0d mismatches", entries_held, errors);
		if (errors == 0 && replies_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
